>>> rtl/fla_pkg.sv
// ----------------------------------------------------------------------------
// fla_pkg
// Shared widths, defaults and codes for the free list slot allocator.
// ----------------------------------------------------------------------------
package fla_pkg;

  localparam int POOL_SLOTS_DEF = 256;
  localparam int SLOT_BYTES_DEF = 64;

  localparam int SLOT_W      = 8;
  localparam int ADDR_W      = 14;
  localparam int STATUS_W    = 2;
  localparam int ACNT_W      = 32;
  localparam int CCNT_W      = 9;
  localparam int CS_W        = 5;
  localparam int IDX_W       = 4;

  localparam logic [CS_W-1:0] CHUNK_RESET = 5'd5;
  localparam logic [CS_W-1:0] MAX_CHUNK   = 5'd16;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FREED     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IGNORED   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_POOL   = 2'd3;

endpackage

>>> rtl/free_list_slot_allocator.sv
// ----------------------------------------------------------------------------
// free_list_slot_allocator
// Fixed-slot pool allocator; the free list links live in one RAM.
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// in_       request    in_valid / in_stall    command, free_slot, free_is_null
// out_      result     out_valid / out_stall  slot, address, status, totals
// cfg_      write      cfg_we                 chunk_slots
//
// Free, ignored or refused request: states idle, exec, resp. Allocate from a
// non-empty list: idle, exec, pop, resp, the pop taking the link RAM read data.
// An empty list first carves a chunk of chunk_slots held to 1..16, then pops.
// Reset clears head, carve pointer and counters; link RAM needs no clearing.
// A stalled result is held in the output register; the next request is taken
// meanwhile and waits only to deliver its own result.
// ----------------------------------------------------------------------------
module free_list_slot_allocator #(
  parameter int POOL_SLOTS = fla_pkg::POOL_SLOTS_DEF,
  parameter int SLOT_BYTES = fla_pkg::SLOT_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [fla_pkg::CS_W-1:0]      cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_command,
  input  logic [fla_pkg::SLOT_W-1:0]    in_free_slot,
  input  logic                          in_free_is_null,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fla_pkg::SLOT_W-1:0]    out_slot,
  output logic [fla_pkg::ADDR_W-1:0]    out_address,
  output logic [fla_pkg::STATUS_W-1:0]  out_status,
  output logic [fla_pkg::ACNT_W-1:0]    out_alloc_total,
  output logic [fla_pkg::CCNT_W-1:0]    out_chunk_total
);

  localparam int AW   = $clog2(POOL_SLOTS);
  localparam int PW   = $clog2(POOL_SLOTS + 1);
  localparam int CMPW = (PW > fla_pkg::SLOT_W) ? PW : fla_pkg::SLOT_W;
  localparam int FW   = (PW + 1 > fla_pkg::CS_W + 1) ? PW + 1 : fla_pkg::CS_W + 1;
  localparam int MW   = (PW + 7 > fla_pkg::ADDR_W) ? PW + 7 : fla_pkg::ADDR_W;
  localparam logic [PW-1:0] NULL_MARK = PW'(POOL_SLOTS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_CARVE = 3'd2;
  localparam logic [2:0] S_POP   = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]                    state_r, state_nxt;
  logic [fla_pkg::CS_W-1:0]      chunk_slots_r, chunk_slots_nxt;
  logic [PW-1:0]                 head_r, head_nxt;
  logic [PW-1:0]                 cp_r, cp_nxt;
  logic [fla_pkg::ACNT_W-1:0]    alloc_cnt_r, alloc_cnt_nxt;
  logic [fla_pkg::CCNT_W-1:0]    chunk_cnt_r, chunk_cnt_nxt;
  logic [fla_pkg::IDX_W-1:0]     idx_r, idx_nxt;
  logic                          cmd_r, cmd_nxt;
  logic [fla_pkg::SLOT_W-1:0]    fslot_r, fslot_nxt;
  logic                          null_r, null_nxt;
  logic [PW-1:0]                 res_slot_r, res_slot_nxt;
  logic [fla_pkg::STATUS_W-1:0]  res_status_r, res_status_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [fla_pkg::SLOT_W-1:0]    out_slot_r, out_slot_nxt;
  logic [fla_pkg::ADDR_W-1:0]    out_addr_r, out_addr_nxt;
  logic [fla_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [fla_pkg::ACNT_W-1:0]    out_atot_r, out_atot_nxt;
  logic [fla_pkg::CCNT_W-1:0]    out_ctot_r, out_ctot_nxt;

  logic                          ram_we, ram_re;
  logic [AW-1:0]                 ram_waddr, ram_raddr;
  logic [PW-1:0]                 ram_wdata, ram_rdata;

  logic [fla_pkg::CS_W-1:0]      n_chunk;
  logic                          fits;
  logic                          carve_last;
  logic [PW-1:0]                 carve_addr;
  logic [CMPW-1:0]               fslot_ext;
  logic [CMPW-1:0]               res_slot_ext;
  logic [MW-1:0]                 addr_prod;

  fla_ram #(
    .WIDTH (PW),
    .DEPTH (POOL_SLOTS)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    if (chunk_slots_r == '0) begin
      n_chunk = 5'd1;
    end else if (chunk_slots_r > fla_pkg::MAX_CHUNK) begin
      n_chunk = fla_pkg::MAX_CHUNK;
    end else begin
      n_chunk = chunk_slots_r;
    end
  end

  assign fits         = (FW'(cp_r) + FW'(n_chunk)) <= FW'(POOL_SLOTS);
  assign carve_last   = (fla_pkg::CS_W'(idx_r) == (n_chunk - 5'd1));
  assign carve_addr   = cp_r + PW'(idx_r);
  assign fslot_ext    = CMPW'(fslot_r);
  assign res_slot_ext = CMPW'(res_slot_r);
  assign addr_prod    = MW'(res_slot_r) * MW'(SLOT_BYTES);

  always_comb begin
    state_nxt       = state_r;
    chunk_slots_nxt = chunk_slots_r;
    head_nxt        = head_r;
    cp_nxt          = cp_r;
    alloc_cnt_nxt   = alloc_cnt_r;
    chunk_cnt_nxt   = chunk_cnt_r;
    idx_nxt         = idx_r;
    cmd_nxt         = cmd_r;
    fslot_nxt       = fslot_r;
    null_nxt        = null_r;
    res_slot_nxt    = res_slot_r;
    res_status_nxt  = res_status_r;
    out_valid_nxt   = out_valid_r;
    out_slot_nxt    = out_slot_r;
    out_addr_nxt    = out_addr_r;
    out_status_nxt  = out_status_r;
    out_atot_nxt    = out_atot_r;
    out_ctot_nxt    = out_ctot_r;
    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_wdata       = '0;
    ram_re          = 1'b0;
    ram_raddr       = head_r[AW-1:0];

    if (cfg_we) begin
      chunk_slots_nxt = cfg_wdata;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_command;
          fslot_nxt = in_free_slot;
          null_nxt  = in_free_is_null;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_slot_nxt = '0;
        if (cmd_r == fla_pkg::CMD_FREE) begin
          if (null_r || fslot_ext >= CMPW'(POOL_SLOTS)) begin
            res_status_nxt = fla_pkg::ST_IGNORED;
          end else begin
            ram_we         = 1'b1;
            ram_waddr      = fslot_ext[AW-1:0];
            ram_wdata      = head_r;
            head_nxt       = fslot_ext[PW-1:0];
            res_status_nxt = fla_pkg::ST_FREED;
          end
          state_nxt = S_RESP;
        end else if (head_r != NULL_MARK) begin
          ram_re    = 1'b1;
          state_nxt = S_POP;
        end else if (fits) begin
          idx_nxt   = '0;
          state_nxt = S_CARVE;
        end else begin
          res_status_nxt = fla_pkg::ST_NO_POOL;
          state_nxt      = S_RESP;
        end
      end
      S_CARVE: begin
        ram_we    = 1'b1;
        ram_waddr = carve_addr[AW-1:0];
        ram_wdata = carve_last ? NULL_MARK : carve_addr + PW'(1);
        if (carve_last) begin
          head_nxt      = cp_r;
          cp_nxt        = cp_r + PW'(n_chunk);
          chunk_cnt_nxt = chunk_cnt_r + 9'd1;
          state_nxt     = S_EXEC;
        end else begin
          idx_nxt = idx_r + 4'd1;
        end
      end
      S_POP: begin
        res_slot_nxt   = head_r;
        res_status_nxt = fla_pkg::ST_ALLOCATED;
        head_nxt       = ram_rdata;
        alloc_cnt_nxt  = alloc_cnt_r + 32'd1;
        state_nxt      = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = res_slot_ext[fla_pkg::SLOT_W-1:0];
          out_addr_nxt   = addr_prod[fla_pkg::ADDR_W-1:0];
          out_status_nxt = res_status_r;
          out_atot_nxt   = alloc_cnt_r;
          out_ctot_nxt   = chunk_cnt_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      chunk_slots_r <= fla_pkg::CHUNK_RESET;
      head_r        <= NULL_MARK;
      cp_r          <= '0;
      alloc_cnt_r   <= '0;
      chunk_cnt_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      chunk_slots_r <= chunk_slots_nxt;
      head_r        <= head_nxt;
      cp_r          <= cp_nxt;
      alloc_cnt_r   <= alloc_cnt_nxt;
      chunk_cnt_r   <= chunk_cnt_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    cmd_r        <= cmd_nxt;
    fslot_r      <= fslot_nxt;
    null_r       <= null_nxt;
    res_slot_r   <= res_slot_nxt;
    res_status_r <= res_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
    out_atot_r   <= out_atot_nxt;
    out_ctot_r   <= out_ctot_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_slot        = out_slot_r;
  assign out_address     = out_addr_r;
  assign out_status      = out_status_r;
  assign out_alloc_total = out_atot_r;
  assign out_chunk_total = out_ctot_r;

`ifndef ASSERT_OFF
  a_carve_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CARVE) |-> (FW'(carve_addr) < FW'(POOL_SLOTS)))
    else $error("carve write beyond pool");

  a_cp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    FW'(cp_r) <= FW'(POOL_SLOTS))
    else $error("carve pointer beyond pool");

  a_pop_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |-> (head_r != NULL_MARK))
    else $error("pop from empty list");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |=> (alloc_cnt_r == $past(alloc_cnt_r) + 32'd1))
    else $error("allocation count not bumped");

  a_carve_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CARVE && carve_last) |=> (state_r == S_EXEC && head_r != NULL_MARK))
    else $error("carve left list empty");
`endif

endmodule

>>> rtl/fla_ram.sv
// ----------------------------------------------------------------------------
// fla_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module fla_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the free list slot allocator: a clocked driver feeds
// requests from a queue, a clocked monitor checks every result against a
// mirror of the pool, with random gaps and back-pressure on both channels and
// several chunk size settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    logic                       command;
    logic [fla_pkg::SLOT_W-1:0] free_slot;
    logic                       free_is_null;
  } request_t;

  typedef struct packed {
    logic [fla_pkg::SLOT_W-1:0]   slot;
    logic [fla_pkg::ADDR_W-1:0]   address;
    logic [fla_pkg::STATUS_W-1:0] status;
    logic [fla_pkg::ACNT_W-1:0]   alloc_total;
    logic [fla_pkg::CCNT_W-1:0]   chunk_total;
  } outcome_t;

  localparam int              LINK_W      = 9;
  localparam logic [LINK_W-1:0] LIST_END  = LINK_W'(fla_pkg::POOL_SLOTS_DEF);
  localparam int              MAX_WAIT    = 12;
  localparam int              PHASES      = 8;
  localparam int              PHASE_ITEMS = 205;
  localparam int              CYCLE_LIMIT = 500000;

  logic                         clk             = 1'b0;
  logic                         rst_n           = 1'b0;
  logic                         cfg_we          = 1'b0;
  logic [fla_pkg::CS_W-1:0]     cfg_wdata       = '0;
  logic                         in_valid        = 1'b0;
  logic                         in_stall;
  logic                         in_command      = fla_pkg::CMD_ALLOC;
  logic [fla_pkg::SLOT_W-1:0]   in_free_slot    = '0;
  logic                         in_free_is_null = 1'b0;
  logic                         out_valid;
  logic                         out_stall       = 1'b0;
  logic [fla_pkg::SLOT_W-1:0]   out_slot;
  logic [fla_pkg::ADDR_W-1:0]   out_address;
  logic [fla_pkg::STATUS_W-1:0] out_status;
  logic [fla_pkg::ACNT_W-1:0]   out_alloc_total;
  logic [fla_pkg::CCNT_W-1:0]   out_chunk_total;

  free_list_slot_allocator uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_free_slot    (in_free_slot),
    .in_free_is_null (in_free_is_null),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_slot        (out_slot),
    .out_address     (out_address),
    .out_status      (out_status),
    .out_alloc_total (out_alloc_total),
    .out_chunk_total (out_chunk_total)
  );

  always #5 clk = ~clk;

  // pool mirror
  logic [LINK_W-1:0]          link_mem [fla_pkg::POOL_SLOTS_DEF];
  logic [LINK_W-1:0]          list_head   = LIST_END;
  int                         carve_next  = 0;
  logic [fla_pkg::ACNT_W-1:0] alloc_count = '0;
  logic [fla_pkg::CCNT_W-1:0] chunk_count = '0;
  logic [fla_pkg::CS_W-1:0]   chunk_cfg   = fla_pkg::CHUNK_RESET;
  int                         held_slots[$];

  request_t request_q[$];
  outcome_t outcome_q[$];
  int       requests_queued = 0;
  int       requests_taken  = 0;
  int       error_count     = 0;
  int       cycle_count     = 0;
  int       status_seen[4]  = '{0, 0, 0, 0};

  function automatic outcome_t apply_request(request_t r);
    outcome_t o;
    int       n;
    int       idx[$];
    o = '0;
    if (r.command == fla_pkg::CMD_ALLOC) begin
      if (list_head == LIST_END) begin
        if (chunk_cfg == '0) n = 1;
        else if (chunk_cfg > fla_pkg::MAX_CHUNK) n = int'(fla_pkg::MAX_CHUNK);
        else n = int'(chunk_cfg);
        if (carve_next + n <= fla_pkg::POOL_SLOTS_DEF) begin
          for (int i = 0; i < n; i++)
            link_mem[carve_next + i] = (i + 1 < n) ? LINK_W'(carve_next + i + 1) : LIST_END;
          list_head = LINK_W'(carve_next);
          carve_next += n;
          chunk_count++;
        end
      end
      if (list_head != LIST_END) begin
        o.slot    = list_head[fla_pkg::SLOT_W-1:0];
        o.address = fla_pkg::ADDR_W'(list_head * fla_pkg::SLOT_BYTES_DEF);
        o.status  = fla_pkg::ST_ALLOCATED;
        held_slots.push_back(int'(list_head));
        list_head = link_mem[list_head];
        alloc_count++;
      end else begin
        o.status = fla_pkg::ST_NO_POOL;
      end
    end else if (r.free_is_null || r.free_slot >= fla_pkg::POOL_SLOTS_DEF) begin
      o.status = fla_pkg::ST_IGNORED;
    end else begin
      link_mem[r.free_slot] = list_head;
      list_head = LINK_W'(r.free_slot);
      o.status = fla_pkg::ST_FREED;
      idx = held_slots.find_first_index(s) with (s == int'(r.free_slot));
      if (idx.size() > 0) held_slots.delete(idx[0]);
    end
    o.alloc_total = alloc_count;
    o.chunk_total = chunk_count;
    return o;
  endfunction

  // driver
  request_t drive_req;
  int       gap_left    = 0;
  bit       drive_burst = 1'b0;

  always @(posedge clk) begin
    logic next_valid;
    if (rst_n) begin
      next_valid = in_valid;
      if (in_valid && !in_stall) begin
        outcome_q.push_back(apply_request(drive_req));
        requests_taken++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_q.size() > 0) begin
          drive_req = request_q.pop_front();
          in_command      <= drive_req.command;
          in_free_slot    <= drive_req.free_slot;
          in_free_is_null <= drive_req.free_is_null;
          next_valid = 1'b1;
          if ($urandom_range(0, 39) == 0) drive_burst = !drive_burst;
          gap_left = drive_burst ? 0 : $urandom_range(0, MAX_WAIT);
        end
      end
      in_valid <= next_valid;
    end
  end

  // monitor
  int stall_left = 0;
  bit sink_burst = 1'b0;

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_slot, out_address, out_status, out_alloc_total, out_chunk_total};
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual slot %0d status %0d",
                   $time, got.slot, got.status);
          error_count++;
        end else begin
          want = outcome_q.pop_front();
          compare_field("slot", want.slot, got.slot);
          compare_field("address", want.address, got.address);
          compare_field("status", want.status, got.status);
          compare_field("alloc_total", want.alloc_total, got.alloc_total);
          compare_field("chunk_total", want.chunk_total, got.chunk_total);
        end
        if (!$isunknown(got.status)) status_seen[got.status]++;
        if ($urandom_range(0, 39) == 0) sink_burst = !sink_burst;
        stall_left = sink_burst ? 0 : $urandom_range(0, MAX_WAIT);
      end
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d requests taken",
               cycle_count, requests_taken, requests_queued);
      $display("[free_list_slot_allocator] ERROR");
      $finish;
    end
  end

  task automatic queue_request(input logic cmd, input logic [fla_pkg::SLOT_W-1:0] s,
                               input logic nul);
    request_q.push_back('{cmd, s, nul});
    requests_queued++;
  endtask

  task automatic queue_random();
    request_t r;
    int       roll;
    r.command      = fla_pkg::CMD_FREE;
    r.free_slot    = fla_pkg::SLOT_W'($urandom());
    r.free_is_null = 1'b0;
    roll = $urandom_range(0, 99);
    if (roll < 62 || (roll < 86 && held_slots.size() == 0)) begin
      r.command      = fla_pkg::CMD_ALLOC;
      r.free_is_null = 1'($urandom_range(0, 1));
    end else if (roll < 86) begin
      r.free_slot = fla_pkg::SLOT_W'(held_slots[$urandom_range(0, held_slots.size() - 1)]);
    end else if (roll >= 91) begin
      r.free_is_null = 1'b1;
    end
    request_q.push_back(r);
    requests_queued++;
  endtask

  task automatic wait_idle();
    while (requests_taken != requests_queued || outcome_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    int settings[PHASES];
    settings = '{0, 16, 31, 1, 17, 0, 0, 0};
    for (int i = 5; i < PHASES; i++) settings[i] = $urandom_range(0, 31);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset chunk size: carving, pops, pushes, null and double frees
    queue_request(fla_pkg::CMD_ALLOC, 8'h00, 1'b0);
    queue_request(fla_pkg::CMD_ALLOC, 8'hFF, 1'b0);
    queue_request(fla_pkg::CMD_FREE,  8'h00, 1'b0);
    queue_request(fla_pkg::CMD_ALLOC, 8'h00, 1'b0);
    queue_request(fla_pkg::CMD_FREE,  8'hFF, 1'b1);
    queue_request(fla_pkg::CMD_FREE,  8'h00, 1'b1);
    queue_request(fla_pkg::CMD_FREE,  8'hFF, 1'b0);
    queue_request(fla_pkg::CMD_ALLOC, 8'h00, 1'b0);
    queue_request(fla_pkg::CMD_ALLOC, 8'hFF, 1'b1);
    queue_request(fla_pkg::CMD_ALLOC, 8'h00, 1'b0);
    queue_request(fla_pkg::CMD_ALLOC, 8'h00, 1'b0);
    queue_request(fla_pkg::CMD_ALLOC, 8'h00, 1'b0);
    queue_request(fla_pkg::CMD_FREE,  8'hAA, 1'b0);
    queue_request(fla_pkg::CMD_FREE,  8'h55, 1'b0);
    queue_request(fla_pkg::CMD_ALLOC, 8'h00, 1'b0);
    queue_request(fla_pkg::CMD_ALLOC, 8'h00, 1'b0);
    queue_request(fla_pkg::CMD_FREE,  8'h00, 1'b0);
    queue_request(fla_pkg::CMD_FREE,  8'h00, 1'b0);
    queue_request(fla_pkg::CMD_ALLOC, 8'h00, 1'b0);
    queue_request(fla_pkg::CMD_ALLOC, 8'h00, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_wdata <= fla_pkg::CS_W'(settings[p]);
      @(posedge clk);
      cfg_we    <= 1'b0;
      chunk_cfg = fla_pkg::CS_W'(settings[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        while (requests_queued - requests_taken > 2) @(posedge clk);
        queue_random();
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    $display("%0d requests: %0d allocated, %0d freed, %0d ignored, %0d refused (pool used up)",
             requests_taken, status_seen[fla_pkg::ST_ALLOCATED],
             status_seen[fla_pkg::ST_FREED], status_seen[fla_pkg::ST_IGNORED],
             status_seen[fla_pkg::ST_NO_POOL]);
    $display("%0d chunks carved, %0d of %0d slots, chunk sizes 5, %0d, %0d, %0d, %0d",
             chunk_count, carve_next, fla_pkg::POOL_SLOTS_DEF, settings[0], settings[1],
             settings[2], settings[3]);
    $display("  then %0d, %0d, %0d, %0d", settings[4], settings[5], settings[6], settings[7]);
    if (error_count == 0) begin
      $display("[free_list_slot_allocator] OK");
    end else begin
      $display("[free_list_slot_allocator] ERROR");
    end
    $finish;
  end

endmodule
